FILE: design/arm_forward_kinematics_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the arm forward kinematics core
// Wrap concurrent checks on clk / rst_n; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ARM_FORWARD_KINEMATICS_CORE_MACROS_SVH
`define ARM_FORWARD_KINEMATICS_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define FKC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define FKC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FKC_ASSERT_SAME(lbl, ante, cons, msg)
`define FKC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: design/fkc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkc_pkg
// Shared types and constants of the forward kinematics datapath.
// ----------------------------------------------------------------------------
package fkc_pkg;

    localparam int HORNER_STEPS = 8;
    localparam int CELL_LAT     = 3;
    // T1, T2, T3 + Horner steps + two final stages
    localparam int LANE_LAT     = 3 + HORNER_STEPS * CELL_LAT + 2;
    localparam int OUT_W        = 20;

    localparam logic [12:0] TURN    = 13'd5760;
    localparam logic [10:0] QUARTER = 11'd1440;
    localparam logic signed [14:0] TURN_S  = 15'sd5760;
    localparam logic signed [14:0] TURN2_S = 15'sd11520;

    // pi in Q30 split as quotient and remainder of a division by 2880
    localparam logic [30:0] PI_QUOT   = 31'd1171270;
    localparam logic [21:0] PI_REM    = 22'd1826;
    localparam logic [21:0] HALF_TURN = 22'd1440;
    // floor(x / 45) = (x * 46604) >> 21 for x < 2^16
    localparam logic [31:0] RECIP_45  = 32'd46604;

    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [63:0] HALF_Q30 = 64'h2000_0000;

    // floor(x / d) = (x * K) >> 41 for x < 2^32
    localparam logic [38:0] HORNER_RECIP [HORNER_STEPS] = '{
        39'(((64'd1 << 41) + 64'd271) / 64'd272),
        39'(((64'd1 << 41) + 64'd209) / 64'd210),
        39'(((64'd1 << 41) + 64'd155) / 64'd156),
        39'(((64'd1 << 41) + 64'd109) / 64'd110),
        39'(((64'd1 << 41) + 64'd71) / 64'd72),
        39'(((64'd1 << 41) + 64'd41) / 64'd42),
        39'(((64'd1 << 41) + 64'd19) / 64'd20),
        39'(((64'd1 << 41) + 64'd5) / 64'd6)
    };

    localparam logic [OUT_W-1:0] OUT_MAX = 20'h7FFFF;
    localparam logic [OUT_W-1:0] OUT_MIN = 20'h80000;

    typedef enum logic [1:0] {
        REG_UPPER_ARM  = 2'd0,
        REG_FOREARM    = 2'd1,
        REG_SHOULDER_H = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [30:0] t;
        logic [31:0] t2;
        logic [30:0] acc;
    } horner_beat_t;

endpackage

FILE: design/fkc_horner_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkc_horner_cell
// One Horner step of the sine series: acc = 1 - round(t2 * acc) / d.
// ----------------------------------------------------------------------------
module fkc_horner_cell #(
    parameter int STEP = 0
) (
    input  logic                 clk,
    input  logic                 en,
    input  fkc_pkg::horner_beat_t din,
    output fkc_pkg::horner_beat_t dout
);

    localparam logic [38:0] K = fkc_pkg::HORNER_RECIP[STEP];

    fkc_pkg::horner_beat_t b1_reg, b2_reg, b3_reg;
    logic [62:0] prod_reg, prod_next;
    logic [51:0] lo_reg, lo_next;
    logic [50:0] hi_reg, hi_next;
    logic [63:0] rnd;
    logic [31:0] p;
    logic [70:0] full;
    logic [30:0] acc_next;

    always_comb
    begin
        prod_next = {31'd0, din.t2} * {32'd0, din.acc};
        rnd       = {1'b0, prod_reg} + fkc_pkg::HALF_Q30;
        p         = rnd[61:30];
        lo_next   = {20'd0, p} * {32'd0, K[19:0]};
        hi_next   = {19'd0, p} * {32'd0, K[38:20]};
        full      = {hi_reg, 20'd0} + {19'd0, lo_reg};
        acc_next  = fkc_pkg::ONE_Q30 - {1'b0, full[70:41]};
    end

    // advance all three stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_reg     <= din;
            prod_reg   <= prod_next;
            b2_reg     <= b1_reg;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            b3_reg     <= '{t: b2_reg.t, t2: b2_reg.t2, acc: acc_next};
        end
    end

    assign dout = b3_reg;

endmodule

FILE: design/fkc_sine_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkc_sine_lane
// First-quadrant sine S(u), u in 0..1440 (1/16 degree), through a row of
// Horner cells. One new angle per enabled cycle.
// ----------------------------------------------------------------------------
module fkc_sine_lane #(
    parameter int TRIG_FRAC_BITS = 16
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [10:0]               u,
    output logic [TRIG_FRAC_BITS:0]   s_out
);

    localparam int TF = TRIG_FRAC_BITS;
    localparam logic [31:0] TRIG_RND = 32'(64'd1 << (29 - TF));

    logic [21:0] m_reg, m_next;
    logic [30:0] base_reg, base_next;
    logic [31:0] qm;
    logic [30:0] t_reg, t_next;
    logic [30:0] t3_reg;
    logic [61:0] tsq;
    logic [62:0] tsq_rnd;
    logic [31:0] t2_reg, t2_next;
    logic [61:0] vprod_reg, vprod_next;
    logic [62:0] vrnd;
    logic [32:0] v;
    logic [31:0] vc;
    logic [31:0] ssum;
    logic [TF:0] s_reg, s_next;

    fkc_pkg::horner_beat_t beat [fkc_pkg::HORNER_STEPS + 1];

    always_comb
    begin
        m_next     = 22'({11'd0, u} * fkc_pkg::PI_REM) + fkc_pkg::HALF_TURN;
        base_next  = {20'd0, u} * fkc_pkg::PI_QUOT;
        qm         = {16'd0, m_reg[21:6]} * fkc_pkg::RECIP_45;
        t_next     = base_reg + {20'd0, qm[31:21]};
        tsq        = {31'd0, t_reg} * {31'd0, t_reg};
        tsq_rnd    = {1'b0, tsq} + fkc_pkg::HALF_Q30[62:0];
        t2_next    = tsq_rnd[61:30];
        vprod_next = {31'd0, beat[fkc_pkg::HORNER_STEPS].t}
                   * {31'd0, beat[fkc_pkg::HORNER_STEPS].acc};
        vrnd       = {1'b0, vprod_reg} + fkc_pkg::HALF_Q30[62:0];
        v          = vrnd[62:30];
        // clamp to one
        vc         = (v > {2'd0, fkc_pkg::ONE_Q30}) ? {1'b0, fkc_pkg::ONE_Q30} : v[31:0];
        ssum       = vc + TRIG_RND;
        s_next     = ssum[30:30-TF];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg     <= m_next;
            base_reg  <= base_next;
            t_reg     <= t_next;
            t3_reg    <= t_reg;
            t2_reg    <= t2_next;
            vprod_reg <= vprod_next;
            s_reg     <= s_next;
        end
    end

    assign beat[0] = '{t: t3_reg, t2: t2_reg, acc: fkc_pkg::ONE_Q30};

    for (genvar i = 0; i < fkc_pkg::HORNER_STEPS; i++)
    begin : g_step
        fkc_horner_cell #(.STEP(i)) u_step (
            .clk  (clk),
            .en   (en),
            .din  (beat[i]),
            .dout (beat[i+1])
        );
    end

    assign s_out = s_reg;

endmodule

FILE: design/arm_forward_kinematics_core.sv
`timescale 1ns / 1ps
`include "arm_forward_kinematics_core_macros.svh"
// ----------------------------------------------------------------------------
// arm_forward_kinematics_core
// End-effector position of a two-link arm on a yawing base.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in      | input     | in_valid/in_stall  | base_yaw, shoulder_pitch,
//          |           |                    | elbow_pitch (s14, 1/16 deg)
//  out     | output    | out_valid/out_stall| pos_x, pos_y, pos_z (s20 Q11.8)
//  cfg     | input     | cfg_we             | cfg_index, cfg_data (16 bit)
//
//  One beat per cycle while the output is not stalled; a beat runs through stage 0,
//  the six sine lanes (eight Horner cells of three stages each) and the product and position registers.
//  Reset clears valids and loads default lengths; there is no clearing pass.
//  A stalled output beat freezes the whole pipeline, and the input stalls.
// ----------------------------------------------------------------------------
module arm_forward_kinematics_core #(
    parameter int TRIG_FRAC_BITS   = 16,
    parameter int LENGTH_FRAC_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [13:0] base_yaw,
    input  logic signed [13:0] shoulder_pitch,
    input  logic signed [13:0] elbow_pitch,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [19:0] pos_x,
    output logic signed [19:0] pos_y,
    output logic signed [19:0] pos_z,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int TF    = TRIG_FRAC_BITS;
    localparam int TW    = TF + 2;           // signed trig value
    localparam int PW    = TF + 19;          // length * trig
    localparam int RW    = TF + 20;          // reach, height
    localparam int XW    = RW + TW;          // reach * trig
    localparam int SH_XY = LENGTH_FRAC_BITS + 2 * TF - 8;
    localparam int SH_Z  = LENGTH_FRAC_BITS + TF - 8;
    localparam int LAT   = fkc_pkg::LANE_LAT;

    // configuration
    logic [15:0] upper_arm_length_reg, forearm_length_reg, shoulder_height_reg;

    // pipeline control
    logic           adv;
    logic           s0_vld_reg;
    logic [LAT-1:0] dly_vld_reg;
    logic           k1_vld_reg, k2_vld_reg, k3_vld_reg, out_vld_reg;

    // stage 0: wrapped angles split into quadrant and rest
    logic [1:0]  quad_reg [3];
    logic [10:0] rem_reg  [3];
    logic [1:0]  quad_next [3];
    logic [10:0] rem_next  [3];
    logic [12:0] m_w [3];
    logic [13:0] mse_sum;
    logic [5:0]  quad_dly_reg [LAT];

    // sine lanes: a = S(rest), b = S(1440 - rest)
    logic [10:0] u_b [3];
    logic [TF:0] s_a [3];
    logic [TF:0] s_b [3];

    logic signed [TW-1:0] sin_w [3];
    logic signed [TW-1:0] cos_w [3];

    logic signed [PW-1:0] p1c_reg, p2c_reg, p1s_reg, p2s_reg;
    logic signed [PW-1:0] p1c_next, p2c_next, p1s_next, p2s_next;
    logic signed [TW-1:0] cb1_reg, sb1_reg, cb2_reg, sb2_reg;
    logic signed [RW-1:0] reach_reg, reach_next, height_reg, height_next;
    logic signed [RW-1:0] hz_reg;
    logic signed [XW-1:0] px_reg, px_next, py_reg, py_next;
    logic signed [XW-1:0] shx, shy;
    logic signed [RW-1:0] shz;
    logic [19:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [19:0] pos_x_next, pos_y_next, pos_z_next;

    function automatic logic [12:0] wrap_turn(input logic [13:0] raw);
        logic signed [14:0] v;
        logic signed [14:0] w;
        v = $signed({raw[13], raw});
        if (v < 15'sd0)
        begin
            if (v < -fkc_pkg::TURN_S)
                w = v + fkc_pkg::TURN2_S;
            else
                w = v + fkc_pkg::TURN_S;
        end
        else if (v >= fkc_pkg::TURN_S)
            w = v - fkc_pkg::TURN_S;
        else
            w = v;
        return w[12:0];
    endfunction

    // hand back the low 20 bits, or the rail when the upper bits disagree
    function automatic logic [19:0] sat_x(input logic signed [XW-1:0] v);
        logic [XW-20:0] hi;
        hi = v[XW-1:19];
        if ((&hi) || !(|hi))
            return v[19:0];
        return v[XW-1] ? fkc_pkg::OUT_MIN : fkc_pkg::OUT_MAX;
    endfunction

    function automatic logic [19:0] sat_z(input logic signed [RW-1:0] v);
        logic [RW-20:0] hi;
        hi = v[RW-1:19];
        if ((&hi) || !(|hi))
            return v[19:0];
        return v[RW-1] ? fkc_pkg::OUT_MIN : fkc_pkg::OUT_MAX;
    endfunction

    assign adv      = !(out_vld_reg && out_stall);
    assign in_stall = !adv;

    // ---- configuration writes; unknown indexes drop the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_arm_length_reg <= 16'd768;
            forearm_length_reg   <= 16'd640;
            shoulder_height_reg  <= 16'd346;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fkc_pkg::REG_UPPER_ARM:  upper_arm_length_reg <= cfg_data;
                fkc_pkg::REG_FOREARM:    forearm_length_reg   <= cfg_data;
                fkc_pkg::REG_SHOULDER_H: shoulder_height_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---- stage 0: wrap angles, form shoulder + elbow, split quadrants
    always_comb
    begin
        m_w[0]  = wrap_turn(base_yaw);
        m_w[1]  = wrap_turn(shoulder_pitch);
        mse_sum = {1'b0, m_w[1]} + {1'b0, wrap_turn(elbow_pitch)};
        m_w[2]  = (mse_sum >= {1'b0, fkc_pkg::TURN}) ?
                  13'(mse_sum - {1'b0, fkc_pkg::TURN}) : mse_sum[12:0];
        for (int j = 0; j < 3; j++)
        begin
            if (m_w[j] < 13'(fkc_pkg::QUARTER))
            begin
                quad_next[j] = 2'd0;
                rem_next[j]  = m_w[j][10:0];
            end
            else if (m_w[j] < 13'(2 * fkc_pkg::QUARTER))
            begin
                quad_next[j] = 2'd1;
                rem_next[j]  = 11'(m_w[j] - 13'(fkc_pkg::QUARTER));
            end
            else if (m_w[j] < 13'(3 * fkc_pkg::QUARTER))
            begin
                quad_next[j] = 2'd2;
                rem_next[j]  = 11'(m_w[j] - 13'(2 * fkc_pkg::QUARTER));
            end
            else
            begin
                quad_next[j] = 2'd3;
                rem_next[j]  = 11'(m_w[j] - 13'(3 * fkc_pkg::QUARTER));
            end
        end
    end

    // ---- valid line: advance only when the output is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg  <= 1'b0;
            dly_vld_reg <= '0;
            k1_vld_reg  <= 1'b0;
            k2_vld_reg  <= 1'b0;
            k3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_vld_reg  <= in_valid;
            dly_vld_reg <= {dly_vld_reg[LAT-2:0], s0_vld_reg};
            k1_vld_reg  <= dly_vld_reg[LAT-1];
            k2_vld_reg  <= k1_vld_reg;
            k3_vld_reg  <= k2_vld_reg;
            out_vld_reg <= k3_vld_reg;
        end
    end

    // ---- sine lanes, two per angle
    for (genvar j = 0; j < 3; j++)
    begin : g_angle
        assign u_b[j] = fkc_pkg::QUARTER - rem_reg[j];

        fkc_sine_lane #(.TRIG_FRAC_BITS(TF)) u_lane_a (
            .clk   (clk),
            .en    (adv),
            .u     (rem_reg[j]),
            .s_out (s_a[j])
        );

        fkc_sine_lane #(.TRIG_FRAC_BITS(TF)) u_lane_b (
            .clk   (clk),
            .en    (adv),
            .u     (u_b[j]),
            .s_out (s_b[j])
        );
    end

    // ---- quadrant fold: sin and cos from the two first-quadrant values
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            case (quad_dly_reg[LAT-1][2*j +: 2])
                2'd0:
                begin
                    sin_w[j] = $signed({1'b0, s_a[j]});
                    cos_w[j] = $signed({1'b0, s_b[j]});
                end
                2'd1:
                begin
                    sin_w[j] = $signed({1'b0, s_b[j]});
                    cos_w[j] = -$signed({1'b0, s_a[j]});
                end
                2'd2:
                begin
                    sin_w[j] = -$signed({1'b0, s_a[j]});
                    cos_w[j] = -$signed({1'b0, s_b[j]});
                end
                default:
                begin
                    sin_w[j] = -$signed({1'b0, s_b[j]});
                    cos_w[j] = $signed({1'b0, s_a[j]});
                end
            endcase
        end
        p1c_next    = $signed({1'b0, upper_arm_length_reg}) * cos_w[1];
        p2c_next    = $signed({1'b0, forearm_length_reg}) * cos_w[2];
        p1s_next    = $signed({1'b0, upper_arm_length_reg}) * sin_w[1];
        p2s_next    = $signed({1'b0, forearm_length_reg}) * sin_w[2];
        reach_next  = RW'(p1c_reg) + RW'(p2c_reg);
        height_next = RW'($signed({1'b0, shoulder_height_reg, {TF{1'b0}}}))
                    + RW'(p1s_reg) + RW'(p2s_reg);
        px_next     = reach_reg * cb2_reg;
        py_next     = reach_reg * sb2_reg;
        // arithmetic shift floors toward negative infinity
        shx         = px_reg >>> SH_XY;
        shy         = py_reg >>> SH_XY;
        shz         = hz_reg >>> SH_Z;
        pos_x_next  = sat_x(shx);
        pos_y_next  = sat_x(shy);
        pos_z_next  = sat_z(shz);
    end

    // ---- payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                quad_reg[j] <= quad_next[j];
                rem_reg[j]  <= rem_next[j];
            end
            quad_dly_reg[0] <= {quad_reg[2], quad_reg[1], quad_reg[0]};
            for (int i = 1; i < LAT; i++)
                quad_dly_reg[i] <= quad_dly_reg[i-1];
            p1c_reg    <= p1c_next;
            p2c_reg    <= p2c_next;
            p1s_reg    <= p1s_next;
            p2s_reg    <= p2s_next;
            cb1_reg    <= cos_w[0];
            sb1_reg    <= sin_w[0];
            reach_reg  <= reach_next;
            height_reg <= height_next;
            cb2_reg    <= cb1_reg;
            sb2_reg    <= sb1_reg;
            px_reg     <= px_next;
            py_reg     <= py_next;
            hz_reg     <= height_reg;
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            pos_z_reg  <= pos_z_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign pos_x     = $signed(pos_x_reg);
    assign pos_y     = $signed(pos_y_reg);
    assign pos_z     = $signed(pos_z_reg);

    `FKC_ASSERT_NEXT(a_in_load, in_valid && !in_stall, s0_vld_reg, "accepted beat lost at entry")
    `FKC_ASSERT_NEXT(a_freeze, out_valid && out_stall, $stable(dly_vld_reg) && $stable(k3_vld_reg), "pipeline moved under stall")
    `FKC_ASSERT_NEXT(a_out_load, k3_vld_reg && !in_stall, out_valid, "finished beat not presented")
    `FKC_ASSERT_SAME(a_stall_src, in_stall, out_valid, "input stalled without a held result")

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arm forward kinematics core testbench
// Drives joint-angle beats through the core under random idling on both
// channels and checks each end-effector position against a bit-exact
// fixed-point predictor of the arm geometry. The lengths and the shoulder
// height are swept between phases, extremes included.
// ----------------------------------------------------------------------------
module testbench;

    localparam int        PIPE_DRAIN  = 40;       // beyond the pipeline latency
    localparam logic [1:0] REG_UNUSED = 2'd3;     // index with no register
    localparam int        MAX_REPORTS = 30;

    typedef struct packed {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] z;
    } position_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [13:0] base_yaw;
    logic signed [13:0] shoulder_pitch;
    logic signed [13:0] elbow_pitch;
    logic               out_valid;
    logic               out_stall;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] pos_z;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    // Geometry as the core should currently hold it
    longint    upper_len;
    longint    fore_len;
    longint    shoulder_h;

    position_t expected_positions[$];
    int        mismatches;
    int        beats_sent;
    int        beats_checked;
    int        settings_used;
    bit        quiet_sender;      // no gaps on the input side
    bit        quiet_receiver;    // no stalls on the output side
    int        long_hold;         // request a long output stall, in cycles

    arm_forward_kinematics_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .base_yaw       (base_yaw),
        .shoulder_pitch (shoulder_pitch),
        .elbow_pitch    (elbow_pitch),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------

    // Reduce any 14 bit pattern to [0, 5760)
    function automatic int wrap_turn(logic signed [13:0] a);
        int v;
        v = int'(a) % 5760;
        if (v < 0)
            v += 5760;
        return v;
    endfunction

    // First-quadrant sine with 16 fraction bits, Horner series in Q30
    function automatic longint quadrant_sine(int u);
        longint unsigned divs [8] = '{272, 210, 156, 110, 72, 42, 20, 6};
        longint unsigned one_q30;
        longint unsigned half_q30;
        longint unsigned t;
        longint unsigned t2;
        longint unsigned acc;
        longint unsigned v;
        one_q30  = 64'd1 << 30;
        half_q30 = 64'd1 << 29;
        t  = (longint'(u) * 64'd3373259426 + 64'd1440) / 64'd2880;
        t2 = (t * t + half_q30) >> 30;
        acc = one_q30;
        for (int i = 0; i < 8; i++)
            acc = one_q30 - (((t2 * acc + half_q30) >> 30) / divs[i]);
        v = (t * acc + half_q30) >> 30;
        if (v > one_q30)
            v = one_q30;
        v = (v + (64'd1 << 13)) >> 14;
        return longint'(v);
    endfunction

    function automatic void sine_cosine(input int m, output longint s, output longint c);
        longint a;
        longint b;
        a = quadrant_sine(m % 1440);
        b = quadrant_sine(1440 - m % 1440);
        case (m / 1440)
            0:       begin s = a;  c = b;  end
            1:       begin s = b;  c = -a; end
            2:       begin s = -a; c = -b; end
            default: begin s = -b; c = a;  end
        endcase
    endfunction

    // Floor toward minus infinity, then clamp to 20 bit signed
    function automatic logic signed [19:0] floor_clamp(longint v, int k);
        longint q;
        q = v >>> k;
        if (q > 524287)
            q = 524287;
        if (q < -524288)
            q = -524288;
        return q[19:0];
    endfunction

    function automatic position_t arm_position(logic signed [13:0] b,
                                               logic signed [13:0] s,
                                               logic signed [13:0] e);
        int        mb;
        int        ms;
        int        mse;
        longint    sb, cb, ss, cs, sse, cse;
        longint    reach;
        longint    height;
        position_t p;
        mb  = wrap_turn(b);
        ms  = wrap_turn(s);
        mse = (ms + wrap_turn(e)) % 5760;
        sine_cosine(mb, sb, cb);
        sine_cosine(ms, ss, cs);
        sine_cosine(mse, sse, cse);
        reach  = upper_len * cs + fore_len * cse;
        height = (shoulder_h <<< 16) + upper_len * ss + fore_len * sse;
        p.x = floor_clamp(reach * cb, 32);
        p.y = floor_clamp(reach * sb, 32);
        p.z = floor_clamp(height, 16);
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Shared drivers and checker
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic signed [19:0] got,
                                   input logic signed [19:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH beat %0d %s: got %0d expected %0d",
                     beats_checked, what, got, want);
    endtask

    // Offer one beat; hold it until the core takes it, then log the prediction
    task automatic send_angles(input logic signed [13:0] b, input logic signed [13:0] s,
                               input logic signed [13:0] e);
        int gap;
        gap = quiet_sender ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        base_yaw       <= b;
        shoulder_pitch <= s;
        elbow_pitch    <= e;
        do
            @(posedge clk);
        while (in_stall);
        expected_positions.push_back(arm_position(b, s, e));
        beats_sent++;
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_angles(14'($urandom), 14'($urandom), 14'($urandom));
    endtask

    // Drain the pipeline, then write one register while idle
    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        in_valid <= 1'b0;
        wait (expected_positions.size() == 0);
        repeat (PIPE_DRAIN) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            fkc_pkg::REG_UPPER_ARM:  upper_len  = value;
            fkc_pkg::REG_FOREARM:    fore_len   = value;
            fkc_pkg::REG_SHOULDER_H: shoulder_h = value;
            default:        ;
        endcase
        settings_used++;
    endtask

    task automatic set_geometry(input logic [15:0] l1, input logic [15:0] l2,
                                input logic [15:0] h);
        write_register(fkc_pkg::REG_UPPER_ARM, l1);
        write_register(fkc_pkg::REG_FOREARM, l2);
        write_register(fkc_pkg::REG_SHOULDER_H, h);
    endtask

    // Compare every accepted output beat with the oldest prediction
    initial
    begin
        position_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_positions.size() == 0)
                begin
                    report_mismatch("unexpected beat", pos_x, 20'sd0);
                end
                else
                begin
                    want = expected_positions.pop_front();
                    if (pos_x !== want.x) report_mismatch("pos_x", pos_x, want.x);
                    if (pos_y !== want.y) report_mismatch("pos_y", pos_y, want.y);
                    if (pos_z !== want.z) report_mismatch("pos_z", pos_z, want.z);
                    beats_checked++;
                end
            end
        end
    end

    // Output stall: a random wait before each beat, or a long hold on request
    initial
    begin
        int w;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (long_hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (long_hold) @(posedge clk);
                long_hold = 0;
            end
            w = quiet_receiver ? 0 : $urandom_range(0, 6);
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall) && long_hold == 0);
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extreme angles, quadrant edges and wrap of out-of-range patterns
    task automatic test_directed_angles();
        send_angles(14'sd0, 14'sd0, 14'sd0);
        send_angles(14'sd1440, 14'sd0, 14'sd0);
        send_angles(14'sd2880, 14'sd1440, 14'sd0);
        send_angles(-14'sd1440, -14'sd1440, 14'sd1440);
        send_angles(14'sd720, 14'sd720, 14'sd720);
        send_angles(14'sd5759, 14'sd5759, 14'sd5759);
        send_angles(-14'sd5760, -14'sd5760, -14'sd5760);
        send_angles(14'sd5760, 14'sd5760, 14'sd2880);     // out of range, wraps
        send_angles(-14'sd8192, -14'sd8192, -14'sd8192);
        send_angles(14'sd8191, 14'sd8191, 14'sd8191);
        send_angles(14'sd1, -14'sd1, 14'sd1439);
        send_angles(14'sd4320, 14'sd2880, -14'sd2880);
        send_angles(14'sd1439, 14'sd1441, 14'sd2879);
        send_angles(14'sd11, 14'sd5000, -14'sd7000);
    endtask

    // Sweep the geometry through its extremes and a few random settings
    task automatic test_geometry_sweep();
        set_geometry(16'd0, 16'd0, 16'd0);
        send_random(20);
        set_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF);
        test_directed_angles();
        send_random(20);
        set_geometry(16'hFFFF, 16'd0, 16'd0);
        send_random(15);
        set_geometry(16'd0, 16'hFFFF, 16'h5555);
        send_random(15);
        write_register(REG_UNUSED, 16'hFFFF);   // must change nothing
        send_random(15);
        for (int i = 0; i < 4; i++)
        begin
            set_geometry(16'($urandom), 16'($urandom), 16'($urandom));
            send_random(40);
        end
    endtask

    // Long random stretches, alternating idle-free and idling phases
    task automatic test_random_motion();
        set_geometry(16'd768, 16'd640, 16'd346);
        for (int i = 0; i < 6; i++)
        begin
            quiet_sender   = (i % 3 == 1);
            quiet_receiver = (i % 2 == 1);
            send_random(80);
        end
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
    endtask

    // Hold the output long enough to fill the pipeline and stall the input
    task automatic test_backpressure();
        quiet_sender = 1'b1;
        long_hold    = 200;
        send_random(80);
        quiet_sender = 1'b0;
    endtask

    // Pause the input until everything has drained, then resume
    task automatic test_drain_pause();
        send_random(20);
        in_valid <= 1'b0;
        wait (expected_positions.size() == 0);
        @(posedge clk);
        send_random(20);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        base_yaw       = '0;
        shoulder_pitch = '0;
        elbow_pitch    = '0;
        cfg_we         = 1'b0;
        cfg_index      = fkc_pkg::REG_UPPER_ARM;
        cfg_data       = '0;
        upper_len      = 768;
        fore_len       = 640;
        shoulder_h     = 346;
        mismatches     = 0;
        beats_sent     = 0;
        beats_checked  = 0;
        settings_used  = 0;
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
        long_hold      = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_angles();
        test_backpressure();
        test_drain_pause();
        test_geometry_sweep();
        test_random_motion();

        // Let the last beats come out, then settle
        in_valid <= 1'b0;
        wait (expected_positions.size() == 0);
        repeat (PIPE_DRAIN) @(posedge clk);

        $display("Covered %0d angle beats, %0d checked, over %0d register writes",
                 beats_sent, beats_checked, settings_used);
        $display("including wrapped angles, zero and full-scale lengths, and a filled pipeline");
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4ms;
        $display("Timeout with %0d results outstanding", expected_positions.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
